/* hdl/assert_macros.svh */
// Assertion macros shared by the fall detector RTL.
// Plain text macros, no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CHK(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");

`endif

/* hdl/fdi_pkg.sv */
// Package for the free-fall / impact fall detector.
// Payload and configuration types, register indexes, phase codes, reset values.
package fdi_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREEFALL_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREEFALL_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMPACT_WINDOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMPACT_LEVEL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_JERK_LEVEL     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_LEVEL     = 3'd6;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_FREEFALL = 2'd1;
  localparam logic [1:0] PH_WAIT     = 2'd2;

  localparam logic [8:0]  ALPHA_MAX     = 9'd256;
  localparam logic [16:0] ONE_G         = 17'd4096;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic        [31:0] time_ms;
  } in_t;

  typedef struct packed {
    logic       fall_alert;
    logic [1:0] phase;
  } out_t;

  typedef struct packed {
    logic [8:0]  smooth_gain;
    logic [16:0] freefall_level;
    logic [15:0] freefall_min_ms;
    logic [15:0] impact_window_ms;
    logic [16:0] impact_level;
    logic [16:0] jerk_level;
    logic [15:0] spin_level;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    smooth_gain:      9'd90,
    freefall_level:   17'd2458,
    freefall_min_ms:  16'd60,
    impact_window_ms: 16'd300,
    impact_level:     17'd6554,
    jerk_level:       17'd2458,
    spin_level:       16'd3200
  };

  // strobes for the bit-serial units
  typedef struct packed {
    logic load;
    logic step;
  } ser_ctrl_t;

  // strobes for the phase tracker
  typedef struct packed {
    logic mul_en;
    logic commit;
  } phs_ctrl_t;

endpackage

/* hdl/fdi_sumsq.sv */
// Bit-serial sum of three squares, MSB first, one multiplier bit per step.
// Depends on fdi_pkg.
module fdi_sumsq import fdi_pkg::*; (
  input  logic               clk_i,
  input  ser_ctrl_t          ctrl_i,
  input  logic signed [15:0] a_i,
  input  logic signed [15:0] b_i,
  input  logic signed [15:0] c_i,
  output logic        [31:0] sum_o
);

  logic [15:0] val_a_q, val_b_q, val_c_q;
  logic [15:0] bit_a_q, bit_b_q, bit_c_q;
  logic [31:0] acc_q;
  logic [15:0] abs_a, abs_b, abs_c;
  logic [17:0] addend;

  assign abs_a = a_i[15] ? 16'(-a_i) : a_i;
  assign abs_b = b_i[15] ? 16'(-b_i) : b_i;
  assign abs_c = c_i[15] ? 16'(-c_i) : c_i;

  assign addend = (bit_a_q[15] ? {2'b00, val_a_q} : 18'd0)
                + (bit_b_q[15] ? {2'b00, val_b_q} : 18'd0)
                + (bit_c_q[15] ? {2'b00, val_c_q} : 18'd0);

  // acc = 2*acc + sum of x*x_i for the current bit i, top bit first
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      val_a_q <= abs_a;
      val_b_q <= abs_b;
      val_c_q <= abs_c;
      bit_a_q <= abs_a;
      bit_b_q <= abs_b;
      bit_c_q <= abs_c;
      acc_q   <= '0;
    end else if (ctrl_i.step) begin
      bit_a_q <= {bit_a_q[14:0], 1'b0};
      bit_b_q <= {bit_b_q[14:0], 1'b0};
      bit_c_q <= {bit_c_q[14:0], 1'b0};
      acc_q   <= {acc_q[30:0], 1'b0} + {14'd0, addend};
    end
  end

  assign sum_o = acc_q;

endmodule

/* hdl/fdi_isqrt.sv */
// Digit-serial floor square root, two radicand bits and one root bit per step.
// Depends on fdi_pkg.
module fdi_isqrt import fdi_pkg::*; (
  input  logic        clk_i,
  input  ser_ctrl_t   ctrl_i,
  input  logic [31:0] rad_i,
  output logic [15:0] root_o
);

  logic [31:0] rad_q;
  logic [16:0] rem_q;
  logic [15:0] root_q;
  logic [31:0] rad_s;
  logic [16:0] rem_s;
  logic [15:0] root_s;
  logic [18:0] rem_w, trial, diff;
  logic        ge;

  // load and first step share a cycle
  assign rad_s  = ctrl_i.load ? rad_i : rad_q;
  assign rem_s  = ctrl_i.load ? 17'd0 : rem_q;
  assign root_s = ctrl_i.load ? 16'd0 : root_q;

  assign rem_w = {rem_s, rad_s[31:30]};
  assign trial = {1'b0, root_s, 2'b01};
  assign ge    = rem_w >= trial;
  assign diff  = rem_w - trial;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      rad_q  <= {rad_s[29:0], 2'b00};
      rem_q  <= ge ? diff[16:0] : rem_w[16:0];
      root_q <= {root_s[14:0], ge};
    end
  end

  assign root_o = root_q;

endmodule

/* hdl/fdi_phase.sv */
// Magnitude filter, jerk/spin checks and the idle / free-fall / wait phase machine.
// Depends on fdi_pkg.
`include "assert_macros.svh"

module fdi_phase import fdi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  phs_ctrl_t   ctrl_i,
  input  cfg_t        cfg_i,
  input  logic [15:0] mag_i,
  input  logic [15:0] spin_i,
  input  logic [31:0] now_i,
  output out_t        res_o
);

  logic [1:0]  phase_q, phase_d;
  logic [16:0] filt_q, last_q;
  logic [31:0] start_q, start_d;
  logic signed [27:0] prod_q;
  logic        shock_q, imp_q;

  logic [8:0]  alpha;
  logic signed [17:0] delta;
  logic [16:0] mag_x, jerk;
  logic signed [19:0] filt_sum;
  logic [16:0] filt_new;
  logic [31:0] elapsed;
  logic        low, alert;

  assign alpha = (cfg_i.smooth_gain > ALPHA_MAX) ? ALPHA_MAX : cfg_i.smooth_gain;
  assign mag_x = {1'b0, mag_i};
  assign delta = $signed({2'b00, mag_i}) - $signed({1'b0, filt_q});
  assign jerk  = (mag_x > last_q) ? (mag_x - last_q) : (last_q - mag_x);

  // on mul_en: product and threshold checks against the old state
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q  <= $signed({1'b0, alpha}) * delta;
      shock_q <= (jerk > cfg_i.jerk_level) && (spin_i > cfg_i.spin_level);
      imp_q   <= mag_x > cfg_i.impact_level;
    end
  end

  // floor divide by 256 is the arithmetic shift
  assign filt_sum = $signed({3'b000, filt_q}) + $signed(prod_q[27:8]);
  assign filt_new = filt_sum[16:0];
  assign low      = filt_new < cfg_i.freefall_level;
  assign elapsed  = now_i - start_q;

  always_comb begin
    phase_d = phase_q;
    start_d = start_q;
    alert   = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (low) begin
          phase_d = PH_FREEFALL;
          start_d = now_i;
        end else if (shock_q) begin
          alert = 1'b1;
        end
      end
      PH_FREEFALL: begin
        if (low) begin
          if (elapsed >= {16'd0, cfg_i.freefall_min_ms}) begin
            phase_d = PH_WAIT;
            start_d = now_i;
          end
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_WAIT: begin
        if (imp_q || shock_q) begin
          alert   = 1'b1;
          phase_d = PH_IDLE;
        end else if (elapsed > {16'd0, cfg_i.impact_window_ms}) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      filt_q  <= ONE_G;
      last_q  <= ONE_G;
      start_q <= '0;
    end else if (ctrl_i.commit) begin
      phase_q <= phase_d;
      filt_q  <= filt_new;
      last_q  <= mag_x;
      start_q <= start_d;
    end
  end

  assign res_o.fall_alert = alert;
  assign res_o.phase      = phase_d;

  // state only moves on a commit
  `ASSERT_CHK(a_phase_hold, clk_i, rst_ni, !ctrl_i.commit |=> $stable(phase_q))
  // an alert always leaves the machine idle
  `ASSERT_CHK(a_alert_idle, clk_i, rst_ni, (ctrl_i.commit && alert) |=> phase_q == PH_IDLE)

endmodule

/* hdl/fall_detector_freefall_impact_top.sv */
// Top level of the free-fall / impact fall detector.
// Depends on fdi_pkg, fdi_sumsq, fdi_isqrt, fdi_phase.
//
// Usage:
//   One inertial sample is an item on the input channel (in_valid_i, in_stall_o,
//   in_data_i); each sample gives exactly one result item on the output channel
//   (out_valid_o, out_stall_i, out_data_o) carrying the alert flag and the phase.
//   An item is accepted when valid is high and stall is low.
//   The squares are formed one multiplier bit per cycle and the square roots
//   one root bit per cycle, followed by the filter product (ST_MUL) and the
//   phase update (ST_COMMIT). Both magnitudes run side by side.
//   in_stall_o is low only in idle, so a new sample is taken only after the
//   previous one has been committed.
//   The result sits in an output register, so the next item is taken while it
//   waits; if the receiver still stalls when the next result is ready, the
//   block holds that result and stalls its input until the register frees.
//   Reset: asynchronous, active low; state, config and phase registers return to
//   defaults: phase idle, filtered and last magnitude one g, no result pending.
//   Configuration: write cfg_we_i / cfg_idx_i / cfg_wdata_i while idle only.
`include "assert_macros.svh"

module fall_detector_freefall_impact_top import fdi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SQ     = 3'd1;
  localparam logic [2:0] ST_RT     = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;
  localparam logic [3:0] CNT_LAST  = 4'd15;

  logic [2:0]  state_q, state_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] now_q;
  logic        out_valid_q, out_valid_d;
  out_t        out_q;
  cfg_t        cfg_q, cfg_d;

  ser_ctrl_t   sq_ctrl, rt_ctrl;
  phs_ctrl_t   ph_ctrl;
  logic        accept, commit;
  logic [31:0] acc_sum, rate_sum;
  logic [15:0] mag, spin;
  out_t        res;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign commit     = (state_q == ST_COMMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    sq_ctrl        = '0;
    rt_ctrl        = '0;
    ph_ctrl        = '0;
    ph_ctrl.commit = commit;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          sq_ctrl.load = 1'b1;
          cnt_d        = '0;
          state_d      = ST_SQ;
        end
      end
      ST_SQ: begin
        sq_ctrl.step = 1'b1;
        cnt_d        = cnt_q + 4'd1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_RT;
        end
      end
      ST_RT: begin
        rt_ctrl.load = (cnt_q == 4'd0);
        rt_ctrl.step = 1'b1;
        cnt_d        = cnt_q + 4'd1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        ph_ctrl.mul_en = 1'b1;
        state_d        = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SMOOTH_GAIN:    cfg_d.smooth_gain      = cfg_wdata_i[8:0];
        REG_FREEFALL_LEVEL: cfg_d.freefall_level   = cfg_wdata_i[16:0];
        REG_FREEFALL_MIN:   cfg_d.freefall_min_ms  = cfg_wdata_i[15:0];
        REG_IMPACT_WINDOW:  cfg_d.impact_window_ms = cfg_wdata_i[15:0];
        REG_IMPACT_LEVEL:   cfg_d.impact_level     = cfg_wdata_i[16:0];
        REG_JERK_LEVEL:     cfg_d.jerk_level       = cfg_wdata_i[16:0];
        REG_SPIN_LEVEL:     cfg_d.spin_level       = cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      cfg_q       <= CFG_RESET;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      cfg_q       <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q <= in_data_i.time_ms;
    end
    if (commit) begin
      out_q <= res;
    end
  end

  fdi_sumsq u_acc_sq (
    .clk_i (clk_i),
    .ctrl_i(sq_ctrl),
    .a_i   (in_data_i.accel_x),
    .b_i   (in_data_i.accel_y),
    .c_i   (in_data_i.accel_z),
    .sum_o (acc_sum)
  );

  fdi_sumsq u_rate_sq (
    .clk_i (clk_i),
    .ctrl_i(sq_ctrl),
    .a_i   (in_data_i.rate_x),
    .b_i   (in_data_i.rate_y),
    .c_i   (in_data_i.rate_z),
    .sum_o (rate_sum)
  );

  fdi_isqrt u_acc_rt (
    .clk_i (clk_i),
    .ctrl_i(rt_ctrl),
    .rad_i (acc_sum),
    .root_o(mag)
  );

  fdi_isqrt u_rate_rt (
    .clk_i (clk_i),
    .ctrl_i(rt_ctrl),
    .rad_i (rate_sum),
    .root_o(spin)
  );

  fdi_phase u_phase (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(ph_ctrl),
    .cfg_i (cfg_q),
    .mag_i (mag),
    .spin_i(spin),
    .now_i (now_q),
    .res_o (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_CHK(a_accept_starts, clk_i, rst_ni, accept |=> state_q == ST_SQ)
  `ASSERT_CHK(a_commit_shows, clk_i, rst_ni, commit |=> out_valid_q)
  `ASSERT_NEVER(a_cnt_idle, clk_i, rst_ni,
                (state_q == ST_IDLE || state_q == ST_MUL) && cnt_q != 4'd0)

endmodule

/* verif/tb_fall_detector_freefall_impact_top.sv */
// Self-checking testbench for fall_detector_freefall_impact_top.
// Uses fdi_pkg for payload and register types; predicts every result in-line and
// checks it against the block under random idling and backpressure.
module tb_fall_detector_freefall_impact_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fdi_pkg::*;

  localparam int                   CYCLE_LIMIT = 1000000;
  localparam int                   DRAIN_WAIT  = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;

  typedef enum int {ACC_REST, ACC_LOW, ACC_MID, ACC_HIGH, ACC_ANY} acc_kind_e;
  typedef enum int {ROT_QUIET, ROT_SPIN, ROT_ANY} rot_kind_e;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // predictor state and register copy
  cfg_t        thr        = CFG_RESET;
  logic [1:0]  ph         = PH_IDLE;
  logic [16:0] filt_mag   = ONE_G;
  logic [16:0] prev_mag   = ONE_G;
  logic [31:0] fall_t0    = '0;

  in_t         sample_q[$];
  out_t        verdict_q[$];
  out_t        want;
  logic [31:0] now_ms     = '0;
  int          tx_gap     = 0;
  int          rx_hold    = 0;
  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  int          n_queued   = 0;
  int          n_checked  = 0;
  int          n_alerts   = 0;
  int          n_waits    = 0;
  int          n_mismatch = 0;
  int          n_cycles   = 0;

  fall_detector_freefall_impact_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- prediction
  function automatic logic [16:0] root_floor(input longint unsigned n);
    logic [16:0] r;
    logic [16:0] t;
    r = '0;
    for (int b = 16; b >= 0; b--) begin
      t = r | (17'd1 << b);
      if (longint'(t) * longint'(t) <= n) r = t;
    end
    return r;
  endfunction

  function automatic logic [16:0] norm3(input logic signed [15:0] a, b, c);
    longint sa, sb, sc;
    sa = a;
    sb = b;
    sc = c;
    return root_floor(sa * sa + sb * sb + sc * sc);
  endfunction

  function automatic out_t detect_fall(input in_t s);
    logic [16:0] mag, spin, jerk;
    logic [8:0]  alpha;
    longint      delta;
    logic        low, shock;
    logic [31:0] elapsed;
    out_t        r;
    mag   = norm3(s.accel_x, s.accel_y, s.accel_z);
    spin  = norm3(s.rate_x, s.rate_y, s.rate_z);
    jerk  = (mag > prev_mag) ? mag - prev_mag : prev_mag - mag;
    alpha = (thr.smooth_gain > ALPHA_MAX) ? ALPHA_MAX : thr.smooth_gain;
    delta = longint'(alpha) * (longint'(mag) - longint'(filt_mag));
    prev_mag = mag;
    // arithmetic shift gives the floor for negative steps
    filt_mag = 17'(longint'(filt_mag) + (delta >>> 8));
    shock    = (jerk > thr.jerk_level) && (spin > thr.spin_level);
    low      = filt_mag < thr.freefall_level;
    elapsed  = s.time_ms - fall_t0;
    r.fall_alert = 1'b0;
    case (ph)
      PH_IDLE: begin
        if (low) begin
          ph      = PH_FREEFALL;
          fall_t0 = s.time_ms;
        end else if (shock) begin
          r.fall_alert = 1'b1;
        end
      end
      PH_FREEFALL: begin
        if (!low) begin
          ph = PH_IDLE;
        end else if (elapsed >= thr.freefall_min_ms) begin
          ph      = PH_WAIT;
          fall_t0 = s.time_ms;
          n_waits++;
        end
      end
      PH_WAIT: begin
        if (mag > thr.impact_level || shock) begin
          r.fall_alert = 1'b1;
          ph           = PH_IDLE;
        end else if (elapsed > thr.impact_window_ms) begin
          ph = PH_IDLE;
        end
      end
      default: ph = PH_IDLE;
    endcase
    r.phase = ph;
    if (r.fall_alert) n_alerts++;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic int draw_gap(input int pct);
    if (int'($urandom_range(99)) >= pct) return 0;
    if ($urandom_range(7) != 0) return $urandom_range(4, 1);
    return $urandom_range(90, 20);
  endfunction

  function automatic logic signed [15:0] jitter(input int span);
    return 16'(int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic logic signed [15:0] big(input int lo, input int hi);
    int v;
    v = int'($urandom_range(hi, lo));
    return $urandom_range(1) ? 16'(v) : 16'(-v);
  endfunction

  function automatic in_t make_item(input acc_kind_e g, input rot_kind_e w);
    in_t              s;
    logic signed [15:0] v;
    int               ax;
    s.accel_x = jitter(300);
    s.accel_y = jitter(300);
    s.accel_z = jitter(300);
    ax = $urandom_range(2);
    v  = '0;
    case (g)
      ACC_REST: v = big(3900, 4300);
      ACC_MID:  v = big(2600, 5500);
      ACC_HIGH: v = big(7000, 32767);
      default:  v = '0;
    endcase
    if (g == ACC_LOW) begin
      s.accel_x = jitter(400);
      s.accel_y = jitter(400);
      s.accel_z = jitter(400);
    end else if (g == ACC_ANY) begin
      s.accel_x = 16'($urandom);
      s.accel_y = 16'($urandom);
      s.accel_z = 16'($urandom);
    end else begin
      case (ax)
        0:       s.accel_x = v;
        1:       s.accel_y = v;
        default: s.accel_z = v;
      endcase
    end
    s.rate_x = jitter(400);
    s.rate_y = jitter(400);
    s.rate_z = jitter(400);
    if (w == ROT_SPIN) begin
      case ($urandom_range(2))
        0:       s.rate_x = big(3300, 32767);
        1:       s.rate_y = big(3300, 32767);
        default: s.rate_z = big(3300, 32767);
      endcase
    end else if (w == ROT_ANY) begin
      s.rate_x = 16'($urandom);
      s.rate_y = 16'($urandom);
      s.rate_z = 16'($urandom);
    end
    s.time_ms = now_ms;
    return s;
  endfunction

  task automatic queue_item(input acc_kind_e g, input rot_kind_e w,
                            input int dt_lo, input int dt_hi);
    now_ms += $urandom_range(dt_hi, dt_lo);
    sample_q.push_back(make_item(g, w));
    n_queued++;
  endtask

  task automatic queue_raw(input logic signed [15:0] ax, ay, az, rx, ry, rz,
                           input logic [31:0] t);
    in_t s;
    s.accel_x = ax;
    s.accel_y = ay;
    s.accel_z = az;
    s.rate_x  = rx;
    s.rate_y  = ry;
    s.rate_z  = rz;
    s.time_ms = t;
    sample_q.push_back(s);
    n_queued++;
  endtask

  // one well-formed motion episode, or a burst of noise
  task automatic queue_episode();
    int pick;
    pick = $urandom_range(99);
    if ($urandom_range(9) == 0) now_ms = 32'hFFFF_FFFF - $urandom_range(300);
    repeat ($urandom_range(4, 1)) queue_item(ACC_REST, ROT_QUIET, 5, 20);
    if (pick < 35) begin
      // free fall then impact
      repeat ($urandom_range(14, 4)) queue_item(ACC_LOW, ROT_QUIET, 5, 20);
      repeat ($urandom_range(3)) queue_item(ACC_LOW, ROT_QUIET, 5, 40);
      queue_item(ACC_HIGH, $urandom_range(1) ? ROT_QUIET : ROT_SPIN, 1, 20);
    end else if (pick < 50) begin
      // free fall, no impact before the window closes
      repeat ($urandom_range(14, 4)) queue_item(ACC_LOW, ROT_QUIET, 5, 20);
      queue_item($urandom_range(1) ? ACC_LOW : ACC_REST, ROT_QUIET, 200, 600);
    end else if (pick < 62) begin
      // free fall ended by jerk with spin, no large impact
      repeat ($urandom_range(14, 4)) queue_item(ACC_LOW, ROT_QUIET, 5, 20);
      queue_item(ACC_MID, ROT_SPIN, 1, 20);
    end else if (pick < 77) begin
      // one spinning sample, high or low, straight from idle
      queue_item($urandom_range(1) ? ACC_HIGH : ACC_LOW, ROT_SPIN, 1, 20);
    end else if (pick < 87) begin
      // brief dip that does not last
      repeat ($urandom_range(5, 1)) queue_item(ACC_LOW, ROT_QUIET, 1, 5);
      queue_item(ACC_REST, ROT_QUIET, 1, 10);
    end else begin
      if ($urandom_range(1)) now_ms = $urandom;
      repeat ($urandom_range(4, 1)) queue_item(ACC_ANY, ROT_ANY, 0, 3000);
    end
  endtask

  task automatic run_random(input int count, input int tx_pct, input int rx_pct);
    int goal;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    goal = n_queued + count;
    while (n_queued < goal) queue_episode();
    wait_drained();
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || in_valid_i || verdict_q.size() != 0);
  endtask

  // ---------------------------------------------------------------- registers
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_SMOOTH_GAIN:    thr.smooth_gain      = val[8:0];
      REG_FREEFALL_LEVEL: thr.freefall_level   = val;
      REG_FREEFALL_MIN:   thr.freefall_min_ms  = val[15:0];
      REG_IMPACT_WINDOW:  thr.impact_window_ms = val[15:0];
      REG_IMPACT_LEVEL:   thr.impact_level     = val;
      REG_JERK_LEVEL:     thr.jerk_level       = val;
      REG_SPIN_LEVEL:     thr.spin_level       = val[15:0];
      default: ;
    endcase
  endtask

  task automatic cfg_close();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic cfg_write_all(input logic [CFG_DATA_W-1:0] val);
    for (int i = 0; i <= int'(REG_SPIN_LEVEL); i++) cfg_write(CFG_IDX_W'(i), val);
    cfg_close();
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    n_mismatch++;
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) verdict_q.push_back(detect_fall(in_data_i));
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap > 0 || sample_q.size() == 0) begin
          in_valid_i <= 1'b0;
          if (tx_gap > 0) tx_gap--;
        end else begin
          in_data_i  <= sample_q.pop_front();
          in_valid_i <= 1'b1;
          tx_gap = draw_gap(tx_idle_pct);
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result item with no sample outstanding");
        end else begin
          want = verdict_q.pop_front();
          if (out_data_o.fall_alert !== want.fall_alert)
            report_mismatch($sformatf("result %0d fall_alert %b, expected %b",
                                      n_checked, out_data_o.fall_alert, want.fall_alert));
          if (out_data_o.phase !== want.phase)
            report_mismatch($sformatf("result %0d phase %0d, expected %0d",
                                      n_checked, out_data_o.phase, want.phase));
          n_checked++;
        end
      end
      if (rx_hold == 0) rx_hold = draw_gap(rx_stall_pct);
      if (rx_hold > 0) begin
        out_stall_i <= 1'b1;
        rx_hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               n_cycles, verdict_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes, a fall across the time wrap, then spin shocks
    queue_raw(-32768, -32768, -32768, -32768, -32768, -32768, 32'd0);
    queue_raw(32767, 32767, 32767, 32767, 32767, 32767, 32'd1);
    for (int k = 0; k < 16; k++) queue_raw(0, 0, 0, 0, 0, 0, 32'hFFFF_FFB0 + 32'(10 * k));
    queue_raw(32767, 0, 0, 0, 0, 0, 32'd85);
    queue_raw(0, 0, 4096, 0, 0, -32768, 32'd90);
    queue_raw(0, 0, -4096, 32767, 0, 0, 32'hFFFF_FFFF);
    wait_drained();

    run_random(300, 30, 30);

    cfg_write(REG_SMOOTH_GAIN, 17'd256);
    cfg_write(REG_FREEFALL_LEVEL, 17'd3000);
    cfg_write(REG_FREEFALL_MIN, 17'd30);
    cfg_write(REG_IMPACT_WINDOW, 17'd150);
    cfg_write(REG_IMPACT_LEVEL, 17'd9000);
    cfg_write(REG_JERK_LEVEL, 17'd1500);
    cfg_write(REG_SPIN_LEVEL, 17'd1000);
    cfg_close();
    run_random(150, 0, 0);

    cfg_write_all('0);
    run_random(80, 50, 20);

    // all ones: alpha saturates, 16-bit registers keep their low bits
    cfg_write_all('1);
    run_random(80, 20, 60);

    cfg_write(REG_SMOOTH_GAIN, 17'd300);
    cfg_write(REG_FREEFALL_LEVEL, 17'($urandom_range(3500, 1500)));
    cfg_write(REG_FREEFALL_MIN, 17'($urandom_range(100)));
    cfg_write(REG_IMPACT_WINDOW, 17'($urandom_range(500, 50)));
    cfg_write(REG_IMPACT_LEVEL, 17'($urandom_range(12000, 5000)));
    cfg_write(REG_JERK_LEVEL, 17'($urandom_range(4000, 1000)));
    cfg_write(REG_SPIN_LEVEL, 17'($urandom_range(6000, 1000)));
    cfg_write(REG_UNUSED, '1);
    cfg_close();
    run_random(170, 40, 40);

    cfg_write(REG_SMOOTH_GAIN, 17'(CFG_RESET.smooth_gain));
    cfg_write(REG_FREEFALL_LEVEL, 17'(CFG_RESET.freefall_level));
    cfg_write(REG_FREEFALL_MIN, 17'(CFG_RESET.freefall_min_ms));
    cfg_write(REG_IMPACT_WINDOW, 17'(CFG_RESET.impact_window_ms));
    cfg_write(REG_IMPACT_LEVEL, 17'(CFG_RESET.impact_level));
    cfg_write(REG_JERK_LEVEL, 17'(CFG_RESET.jerk_level));
    cfg_write(REG_SPIN_LEVEL, 17'(CFG_RESET.spin_level));
    cfg_close();
    run_random(170, 30, 30);

    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Checked %0d results over six register settings: %0d falls flagged,",
             n_checked, n_alerts);
    $display("%0d entries into the impact wait, %0d mismatches.", n_waits, n_mismatch);
    if (n_mismatch == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/fdi_pkg.sv
hdl/fdi_sumsq.sv
hdl/fdi_isqrt.sv
hdl/fdi_phase.sv
hdl/fall_detector_freefall_impact_top.sv
verif/tb_fall_detector_freefall_impact_top.sv
